### rtl/gn3d_pkg.sv
// Package for the 3D gradient noise block: permutation ROM, sequencer
// states, widths. No dependencies.
package gn3d_pkg;

	localparam int CoordW = 32;
	localparam int FracW  = 16;
	localparam int GradW  = 16;
	localparam int EntryW = 3 * GradW;
	// corner dot products: Q1.15 by 17-bit signed offset, three terms
	localparam int DotW   = 35;
	localparam int OutW   = 16;

	typedef enum logic [0:0] {
		OP_EVAL = 1'b0,
		OP_LOAD = 1'b1
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_HASH_Z,
		ST_HASH_Y,
		ST_HASH_X,
		ST_WEIGHT,
		ST_CORNER,
		ST_LERP,
		ST_OUT
	} state_t;

	localparam logic [7:0] PERM [256] = '{
		8'd225, 8'd155, 8'd210, 8'd108, 8'd175, 8'd199, 8'd221, 8'd144,
		8'd203, 8'd116, 8'd5, 8'd82, 8'd173, 8'd133, 8'd222, 8'd139,
		8'd174, 8'd169, 8'd138, 8'd248, 8'd36, 8'd2, 8'd151, 8'd194,
		8'd235, 8'd65, 8'd224, 8'd217, 8'd27, 8'd81, 8'd7, 8'd22,
		8'd121, 8'd229, 8'd63, 8'd8, 8'd165, 8'd110, 8'd237, 8'd117,
		8'd231, 8'd51, 8'd172, 8'd157, 8'd47, 8'd162, 8'd115, 8'd44,
		8'd43, 8'd124, 8'd94, 8'd150, 8'd53, 8'd131, 8'd84, 8'd57,
		8'd220, 8'd197, 8'd58, 8'd24, 8'd15, 8'd179, 8'd18, 8'd215,
		8'd153, 8'd26, 8'd200, 8'd226, 8'd119, 8'd12, 8'd76, 8'd34,
		8'd187, 8'd140, 8'd164, 8'd236, 8'd232, 8'd120, 8'd70, 8'd213,
		8'd69, 8'd158, 8'd33, 8'd252, 8'd90, 8'd246, 8'd75, 8'd130,
		8'd91, 8'd191, 8'd25, 8'd113, 8'd228, 8'd159, 8'd205, 8'd253,
		8'd134, 8'd142, 8'd89, 8'd103, 8'd96, 8'd104, 8'd156, 8'd80,
		8'd212, 8'd176, 8'd250, 8'd16, 8'd141, 8'd247, 8'd50, 8'd208,
		8'd39, 8'd49, 8'd32, 8'd10, 8'd198, 8'd223, 8'd255, 8'd11,
		8'd241, 8'd46, 8'd31, 8'd123, 8'd168, 8'd125, 8'd249, 8'd17,
		8'd201, 8'd129, 8'd20, 8'd181, 8'd111, 8'd239, 8'd218, 8'd87,
		8'd55, 8'd73, 8'd112, 8'd182, 8'd244, 8'd195, 8'd227, 8'd1,
		8'd243, 8'd148, 8'd102, 8'd166, 8'd28, 8'd99, 8'd242, 8'd136,
		8'd189, 8'd72, 8'd3, 8'd192, 8'd62, 8'd202, 8'd6, 8'd128,
		8'd167, 8'd23, 8'd188, 8'd13, 8'd35, 8'd77, 8'd196, 8'd185,
		8'd68, 8'd183, 8'd230, 8'd177, 8'd135, 8'd160, 8'd180, 8'd38,
		8'd238, 8'd251, 8'd37, 8'd240, 8'd126, 8'd64, 8'd74, 8'd161,
		8'd40, 8'd66, 8'd29, 8'd59, 8'd146, 8'd61, 8'd254, 8'd107,
		8'd42, 8'd86, 8'd154, 8'd4, 8'd21, 8'd233, 8'd209, 8'd45,
		8'd98, 8'd193, 8'd114, 8'd184, 8'd149, 8'd171, 8'd178, 8'd101,
		8'd48, 8'd41, 8'd71, 8'd56, 8'd132, 8'd211, 8'd152, 8'd170,
		8'd163, 8'd106, 8'd9, 8'd79, 8'd147, 8'd85, 8'd30, 8'd207,
		8'd219, 8'd137, 8'd214, 8'd145, 8'd93, 8'd92, 8'd100, 8'd245,
		8'd54, 8'd78, 8'd19, 8'd206, 8'd88, 8'd234, 8'd190, 8'd122,
		8'd0, 8'd216, 8'd186, 8'd60, 8'd95, 8'd83, 8'd105, 8'd14,
		8'd118, 8'd127, 8'd67, 8'd143, 8'd109, 8'd97, 8'd204, 8'd52
	};

endpackage

### rtl/gn3d_if.sv
// Valid/ready channel interfaces for the gradient noise block.
// Depends on gn3d_pkg.
interface gn3d_in_if
	import gn3d_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic                     operation;
	logic signed [CoordW-1:0] x_coord;
	logic signed [CoordW-1:0] y_coord;
	logic signed [CoordW-1:0] z_coord;
	logic [7:0]               entry_index;
	logic signed [GradW-1:0]  grad_x;
	logic signed [GradW-1:0]  grad_y;
	logic signed [GradW-1:0]  grad_z;

	modport source (output valid, operation, x_coord, y_coord, z_coord, entry_index,
		grad_x, grad_y, grad_z, input ready);
	modport sink (input valid, operation, x_coord, y_coord, z_coord, entry_index,
		grad_x, grad_y, grad_z, output ready);
endinterface

interface gn3d_out_if
	import gn3d_pkg::*;
();
	logic                   valid;
	logic                   ready;
	logic signed [OutW-1:0] noise_value;

	modport source (output valid, noise_value, input ready);
	modport sink (input valid, noise_value, output ready);
endinterface

### rtl/gn3d_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module gn3d_ram #(
	parameter int Width = 48,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

### rtl/gn3d_mac.sv
// Shared signed multiply-accumulate unit: one 19x19 product per cycle,
// optionally arithmetic-shifted right by 16 and added to an addend.
// Depends on gn3d_pkg.
module gn3d_mac
	import gn3d_pkg::*;
(
	input  logic               clk,
	input  logic signed [18:0] a,
	input  logic signed [18:0] b,
	input  logic               shift16,
	input  logic signed [47:0] addend,
	output logic signed [47:0] result
);
	logic signed [37:0] prod;
	logic signed [47:0] term;

	// product, optionally floored by 2^16, plus addend
	always_comb begin
		prod = a * b;
		term = shift16 ? 48'(prod >>> 16) : 48'(prod);
	end

	always_ff @(posedge clk) begin
		result <= term + addend;
	end
endmodule

### rtl/gradient_noise_3d.sv
// Top level of the 3D gradient noise block: sequencer, hash, gradient RAM.
// Depends on gn3d_pkg, gn3d_if, gn3d_ram, gn3d_mac.
//
// Usage: items arrive on in_ch (valid/ready). A load item (operation 1)
// writes one gradient entry as it is accepted and gives no result. An
// evaluate item (operation 0) gives one noise_value item on out_ch.
// Sequence: an evaluate walks one shared 19x19 multiply-add unit through the
// hash states ST_HASH_Z and ST_HASH_Y, the smoothstep weights (ST_WEIGHT), the
// eight corners (a gradient RAM read in ST_HASH_X, then ST_CORNER for each),
// seven lerps (ST_LERP) and the output state ST_OUT. in_ch is not ready while
// an evaluate is in progress; it is ready again as the result enters the
// output register. A load leaves the block idle, so in_ch stays ready.
// The result waits in an output register. While out_ch is stalled the block
// still takes new items; a second finished evaluate holds in its last state
// until the register is free. Reset clears the sequencer and output valid;
// the gradient memory is not cleared and must be loaded before use.
module gradient_noise_3d
	import gn3d_pkg::*;
#(
	parameter int TABLE_SIZE = 256
) (
	input logic       clk,
	input logic       arst_n,
	gn3d_in_if.sink   in_ch,
	gn3d_out_if.source out_ch
);
	localparam int AW = $clog2(TABLE_SIZE);

	// constant table of 8-bit index modulo TABLE_SIZE
	function automatic logic [256*AW-1:0] wrap_table();
		logic [256*AW-1:0] t;
		t = '0;
		for (int i = 0; i < 256; i++) t[i*AW +: AW] = AW'(i % TABLE_SIZE);
		return t;
	endfunction

	localparam logic [256*AW-1:0] WrapTbl = wrap_table();

	state_t state_q;
	logic [4:0] step_q;
	logic [2:0] cidx_q;
	logic [15:0] fx_q, fy_q, fz_q;
	logic [7:0] ix_q, iy_q, iz_q;
	logic [7:0] hz_q [2];
	logic [7:0] hy_q [4];
	logic [7:0] hsel;
	logic signed [47:0] w_q [3];
	logic signed [47:0] v_q [8];
	logic signed [47:0] acc;
	logic signed [18:0] ma, mb;
	logic msh;
	logic signed [47:0] madd;
	logic [EntryW-1:0] rd;
	logic ram_we;
	logic [AW-1:0] ram_addr;
	logic [15:0] outv_q;
	logic ovalid_q;
	logic out_go;
	logic [2:0] lidx_q;
	logic signed [47:0] aop, bop, wsel, diff;

	gn3d_mac u_mac (.clk, .a(ma), .b(mb), .shift16(msh), .addend(madd), .result(acc));

	gn3d_ram #(.Width(EntryW), .Depth(TABLE_SIZE)) u_ram (
		.clk, .we(ram_we), .addr(ram_addr),
		.wdata({in_ch.grad_x, in_ch.grad_y, in_ch.grad_z}), .rdata(rd));

	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_ch.valid = ovalid_q;
	assign out_ch.noise_value = outv_q;

	logic acc_in;
	assign acc_in = in_ch.valid && in_ch.ready;

	// result leaves ST_OUT once the output register is free or being drained
	assign out_go = (state_q == ST_OUT) && (!ovalid_q || out_ch.ready);

	// corner hash (combinational over registered partial hashes)
	always_comb begin
		hsel = PERM[8'(ix_q + {7'd0, cidx_q[0]} +
			hy_q[{cidx_q[2], cidx_q[1]}])];
	end

	always_comb begin
		ram_we = acc_in && (in_ch.operation == OP_LOAD);
		if (ram_we) ram_addr = WrapTbl[int'(in_ch.entry_index)*AW +: AW];
		else ram_addr = WrapTbl[int'(hsel)*AW +: AW];
	end

	// offset component for current corner
	function automatic logic signed [18:0] offs(input logic [15:0] f, input logic far);
		offs = far ? $signed({3'b000, f}) - 19'sd65536 : $signed({3'b000, f});
	endfunction

	// MAC operand schedule; a product issued in one step is in acc the next
	logic signed [47:0] tmp_q;
	logic [1:0] ax;
	logic [15:0] fsel;
	always_comb begin
		ax = step_q[3:2];
		case (ax)
			2'd0: fsel = fx_q;
			2'd1: fsel = fy_q;
			default: fsel = fz_q;
		endcase
	end

	// lerp operand selection: seven lerps over v_q
	always_comb begin
		case (lidx_q)
			3'd0: begin aop = v_q[0]; bop = v_q[1]; wsel = w_q[0]; end
			3'd1: begin aop = v_q[2]; bop = v_q[3]; wsel = w_q[0]; end
			3'd2: begin aop = v_q[0]; bop = v_q[2]; wsel = w_q[1]; end
			3'd3: begin aop = v_q[4]; bop = v_q[5]; wsel = w_q[0]; end
			3'd4: begin aop = v_q[6]; bop = v_q[7]; wsel = w_q[0]; end
			3'd5: begin aop = v_q[4]; bop = v_q[6]; wsel = w_q[1]; end
			default: begin aop = v_q[0]; bop = v_q[4]; wsel = w_q[2]; end
		endcase
		diff = bop - aop;
	end

	// weight = floor(f*f*t/2^32): with p=f*f (32b) split p = ph*2^16+pl,
	// w = floor((ph*t + floor(pl*t/2^16))/2^16)
	always_comb begin
		ma = '0; mb = '0; msh = 1'b0; madd = '0;
		case (state_q)
			ST_WEIGHT: begin
				case (step_q[1:0])
					2'd0: begin
						ma = $signed({3'b000, fsel}); mb = $signed({3'b000, fsel});
					end
					2'd1: begin // pl * t >> 16
						ma = $signed({3'b000, acc[15:0]});
						mb = 19'sd196608 - $signed({2'b00, fsel, 1'b0});
						msh = 1'b1;
					end
					2'd2: begin // ph * t + acc
						ma = $signed({3'b000, tmp_q[31:16]});
						mb = 19'sd196608 - $signed({2'b00, fsel, 1'b0});
						madd = acc;
					end
					default: ;
				endcase
			end
			ST_CORNER: begin
				case (step_q[1:0])
					2'd0: begin
						ma = 19'($signed(rd[47:32])); mb = offs(fx_q, cidx_q[0]);
					end
					2'd1: begin
						ma = 19'($signed(rd[31:16])); mb = offs(fy_q, cidx_q[1]);
						madd = acc;
					end
					default: begin
						ma = 19'($signed(rd[15:0])); mb = offs(fz_q, cidx_q[2]);
						madd = acc;
					end
				endcase
			end
			ST_LERP: begin
				// b-a fits 35 bits: split into a signed 19-bit hi and an unsigned 16-bit lo part
				case (step_q[1:0])
					2'd0: begin // lo part * w, floor >>16
						ma = $signed({3'b000, diff[15:0]});
						mb = 19'(wsel);
						msh = 1'b1;
					end
					2'd1: begin // hi part * w + acc + a
						ma = $signed(diff[34:16]);
						mb = 19'(wsel);
						madd = acc + aop;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// result saturation
	logic signed [47:0] rfin;
	logic [15:0] sat;
	always_comb begin
		rfin = v_q[0] >>> 16;
		if (rfin > 48'sd32767) sat = 16'h7fff;
		else if (rfin < -48'sd32768) sat = 16'h8000;
		else sat = rfin[15:0];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			cidx_q <= '0;
			lidx_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (out_go) ovalid_q <= 1'b1;
			else if (out_ch.ready) ovalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (acc_in && in_ch.operation == OP_EVAL) begin
						state_q <= ST_HASH_Z;
					end
				end
				ST_HASH_Z: state_q <= ST_HASH_Y;
				ST_HASH_Y: begin
					state_q <= ST_WEIGHT;
					step_q <= '0;
				end
				ST_WEIGHT: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'd11) begin
						state_q <= ST_HASH_X;
						cidx_q <= '0;
					end
				end
				ST_HASH_X: begin // RAM read in flight
					state_q <= ST_CORNER;
					step_q <= '0;
				end
				ST_CORNER: begin
					if (step_q == 5'd3) begin
						cidx_q <= cidx_q + 3'd1;
						state_q <= (cidx_q == 3'd7) ? ST_LERP : ST_HASH_X;
						step_q <= '0;
						lidx_q <= '0;
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
				ST_LERP: begin
					if (step_q == 5'd2) begin
						step_q <= '0;
						lidx_q <= lidx_q + 3'd1;
						if (lidx_q == 3'd6) state_q <= ST_OUT;
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
				ST_OUT: begin
					if (out_go) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (acc_in) begin
					fx_q <= in_ch.x_coord[15:0];
					fy_q <= in_ch.y_coord[15:0];
					fz_q <= in_ch.z_coord[15:0];
					ix_q <= in_ch.x_coord[23:16];
					iy_q <= in_ch.y_coord[23:16];
					iz_q <= in_ch.z_coord[23:16];
				end
			end
			ST_HASH_Z: begin
				hz_q[0] <= PERM[iz_q];
				hz_q[1] <= PERM[8'(iz_q + 8'd1)];
			end
			ST_HASH_Y: begin
				hy_q[0] <= PERM[8'(iy_q + hz_q[0])];
				hy_q[1] <= PERM[8'(iy_q + 8'd1 + hz_q[0])];
				hy_q[2] <= PERM[8'(iy_q + hz_q[1])];
				hy_q[3] <= PERM[8'(iy_q + 8'd1 + hz_q[1])];
			end
			ST_WEIGHT: begin
				// step 1: acc holds f*f; step 3: acc holds weight*2^16 plus fraction
				if (step_q[1:0] == 2'd1) tmp_q <= acc;
				if (step_q[1:0] == 2'd3) w_q[ax] <= acc >>> 16;
			end
			ST_CORNER: begin
				if (step_q[1:0] == 2'd3) v_q[cidx_q] <= acc;
			end
			ST_LERP: begin
				if (step_q[1:0] == 2'd2) begin
					case (lidx_q)
						3'd0, 3'd2: v_q[0] <= acc;
						3'd1: v_q[2] <= acc;
						3'd3, 3'd5: v_q[4] <= acc;
						3'd4: v_q[6] <= acc;
						default: v_q[0] <= acc;
					endcase
				end
			end
			ST_OUT: begin
				if (out_go) outv_q <= sat;
			end
			default: ;
		endcase
	end
endmodule

### tb/tb_top.sv
// Self-checking testbench for gradient_noise_3d: loads the gradient table, runs
// a directed table and random loads/evaluates under varying handshake idling.
// Depends on gn3d_pkg, gn3d_if and the gradient_noise_3d RTL.
module tb_top;
	import gn3d_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NumRandom  = 1570;
	localparam int StallLimit = 5000;
	localparam int DrainWait  = 100;

	typedef struct {
		op_t               op;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [7:0]         idx;
		logic signed [15:0] gx;
		logic signed [15:0] gy;
		logic signed [15:0] gz;
		bit                 typed;
		logic signed [15:0] noise;
	} item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	gn3d_in_if  in_ch ();
	gn3d_out_if out_ch ();

	gradient_noise_3d #(.TABLE_SIZE(256)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// gradient table mirror and pending noise values
	logic signed [15:0] grad_mirror [256][3];
	logic signed [15:0] noise_due [$];
	int errors = 0;
	int loads_sent = 0;
	int evals_sent = 0;
	int noise_seen = 0;
	int idle_phase = 0;
	int quiet_cycles = 0;
	bit timed_out = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(string what, logic signed [15:0] got,
		logic signed [15:0] want);
		errors++;
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
	endtask

	// smoothstep weight, Q0.16
	function automatic longint weight_of(longint f);
		longint unsigned fu;
		fu = f;
		return longint'((fu * fu * (64'd196608 - 2 * fu)) >> 32);
	endfunction

	function automatic longint lerp_q16(longint w, longint a, longint b);
		return a + (((b - a) * w) >>> 16);
	endfunction

	// gradient at hashed corner dotted with the offset from it
	function automatic longint corner_dot(int cx, int cy, int cz,
		longint ox, longint oy, longint oz);
		int h;
		h = PERM[cz & 255];
		h = PERM[(cy + h) & 255];
		h = PERM[(cx + h) & 255];
		return longint'(grad_mirror[h][0]) * ox + longint'(grad_mirror[h][1]) * oy
			+ longint'(grad_mirror[h][2]) * oz;
	endfunction

	function automatic logic signed [15:0] noise_at(logic [31:0] x, logic [31:0] y,
		logic [31:0] z);
		longint fx, fy, fz, wx, wy, wz, lo, hi, r;
		longint c [8];
		int dx, dy, dz;
		fx = x[15:0];
		fy = y[15:0];
		fz = z[15:0];
		wx = weight_of(fx);
		wy = weight_of(fy);
		wz = weight_of(fz);
		for (int k = 0; k < 8; k++) begin
			dx = k & 1;
			dy = (k >> 1) & 1;
			dz = (k >> 2) & 1;
			c[k] = corner_dot(x[23:16] + dx, y[23:16] + dy, z[23:16] + dz,
				fx - dx * 65536, fy - dy * 65536, fz - dz * 65536);
		end
		lo = lerp_q16(wy, lerp_q16(wx, c[0], c[1]), lerp_q16(wx, c[2], c[3]));
		hi = lerp_q16(wy, lerp_q16(wx, c[4], c[5]), lerp_q16(wx, c[6], c[7]));
		r = lerp_q16(wz, lo, hi) >>> 16;
		if (r > 32767)
			r = 32767;
		if (r < -32768)
			r = -32768;
		return r[15:0];
	endfunction

	function automatic item_t load_item(int idx, int gx, int gy, int gz);
		item_t it;
		it = '{op: OP_LOAD, x: $urandom, y: $urandom, z: $urandom, idx: 8'(idx),
			gx: 16'(gx), gy: 16'(gy), gz: 16'(gz), typed: 0, noise: 16'd0};
		return it;
	endfunction

	function automatic item_t eval_item(logic [31:0] x, logic [31:0] y, logic [31:0] z,
		bit typed, int noise);
		item_t it;
		it = '{op: OP_EVAL, x: x, y: y, z: z, idx: 8'($urandom), gx: 16'($urandom),
			gy: 16'($urandom), gz: 16'($urandom), typed: typed, noise: 16'(noise)};
		return it;
	endfunction

	function automatic int grad_pick();
		case ($urandom_range(0, 5))
			0: return -32768;
			1: return 32767;
			default: return int'($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	function automatic logic [31:0] coord_pick();
		if ($urandom_range(0, 1))
			return $urandom;
		return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
	endfunction

	// drive one item, idling first per phase; update the mirror at acceptance
	task automatic send_item(item_t it);
		int idle_pct;
		idle_pct = (idle_phase == 0) ? 36 : (idle_phase == 1) ? 50 : 0;
		while ($urandom_range(0, 99) < idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.operation   <= it.op;
		in_ch.x_coord     <= it.x;
		in_ch.y_coord     <= it.y;
		in_ch.z_coord     <= it.z;
		in_ch.entry_index <= it.idx;
		in_ch.grad_x      <= it.gx;
		in_ch.grad_y      <= it.gy;
		in_ch.grad_z      <= it.gz;
		do
			@(posedge clk);
		while (!in_ch.ready);
		if (it.op == OP_LOAD) begin
			grad_mirror[it.idx] = '{it.gx, it.gy, it.gz};
			loads_sent++;
		end else begin
			noise_due.push_back(it.typed ? it.noise : noise_at(it.x, it.y, it.z));
			evals_sent++;
		end
	endtask

	// result side: check, then pick ready for the next cycle
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			noise_seen++;
			if (noise_due.size() == 0) begin
				report_mismatch("noise_value with none pending", out_ch.noise_value, 16'sd0);
			end else if (out_ch.noise_value !== noise_due[0]) begin
				report_mismatch("noise_value", out_ch.noise_value, noise_due.pop_front());
			end else begin
				void'(noise_due.pop_front());
			end
		end
		case (idle_phase)
			0: out_ch.ready <= ($urandom_range(0, 99) >= 50);
			1: out_ch.ready <= ($urandom_range(0, 99) >= 36);
			default: out_ch.ready <= 1'b1;
		endcase
	end

	// watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= StallLimit && !timed_out) begin
			timed_out = 1;
			$display("Watchdog expired: %0d evaluates pending", noise_due.size());
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		item_t directed [$];
		item_t it;
		in_ch.valid       = 1'b0;
		in_ch.operation   = OP_EVAL;
		in_ch.x_coord     = '0;
		in_ch.y_coord     = '0;
		in_ch.z_coord     = '0;
		in_ch.entry_index = '0;
		in_ch.grad_x      = '0;
		in_ch.grad_y      = '0;
		in_ch.grad_z      = '0;
		out_ch.ready      = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the whole table so no evaluate reads an unwritten entry
		for (int i = 0; i < 256; i++)
			send_item(load_item(i, grad_pick(), grad_pick(), grad_pick()));

		// directed: lattice points give zero, then extremes and floor of negatives
		directed.push_back(eval_item(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1, 0));
		directed.push_back(eval_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 0));
		directed.push_back(eval_item(32'h7FFF_0000, 32'hFFFF_0000, 32'h0001_0000, 1, 0));
		directed.push_back(eval_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0));
		directed.push_back(eval_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0));
		directed.push_back(eval_item(32'h8000_0001, 32'h0000_0001, 32'hFFFE_8000, 0, 0));
		directed.push_back(eval_item(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 0, 0));
		directed.push_back(eval_item(32'h00FF_C000, 32'h00FF_4000, 32'h00FF_FFFF, 0, 0));
		directed.push_back(load_item(0, -32768, -32768, -32768));
		directed.push_back(load_item(255, 32767, 32767, 32767));
		directed.push_back(load_item(128, 0, -1, 32767));
		directed.push_back(eval_item(32'h00F8_8000, 32'hFFFF_8000, 32'h0003_2000, 0, 0));
		directed.push_back(eval_item(32'hFF00_FFFF, 32'h00FF_0001, 32'h8000_8000, 0, 0));
		directed.push_back(eval_item(32'h0042_0000, 32'h0017_0000, 32'hFFAB_0000, 1, 0));
		for (int i = 0; i < 6; i++)
			directed.push_back(eval_item($urandom, $urandom, $urandom, 0, 0));
		foreach (directed[i])
			send_item(directed[i]);

		// random: mostly evaluates, some loads, idling changes by thirds
		for (int n = 0; n < NumRandom; n++) begin
			idle_phase = n * 3 / NumRandom;
			if ($urandom_range(0, 99) < 18)
				it = load_item($urandom_range(0, 255), grad_pick(), grad_pick(), grad_pick());
			else
				it = eval_item(coord_pick(), coord_pick(), coord_pick(), 0, 0);
			send_item(it);
		end
		in_ch.valid <= 1'b0;

		wait (noise_due.size() == 0);
		repeat (DrainWait) @(posedge clk);
		$display("Sent %0d loads and %0d evaluates; %0d noise items checked.",
			loads_sent, evals_sent, noise_seen);
		$display("Covered lattice points, coordinate extremes and three idling phases.");
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches", errors);
			$display("Verification failed");
		end
		$finish;
	end
endmodule
